// File: hw/rtl/loc_pkg.sv
// Shared types, constants and helpers for the order book matcher.
package loc_pkg;

  localparam int ORDER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(ORDER_SLOTS);
  localparam int SCAN_W      = $clog2(ORDER_SLOTS + 2);
  localparam int AVAIL_W     = 32 + SLOT_W + 1;

  localparam logic [15:0] PRICE_MAX = 16'hFFFF;
  localparam logic [15:0] PRICE_MIN = 16'h0000;

  // Commands and order types
  localparam logic       CMD_NEW    = 1'b0;
  localparam logic       CMD_CANCEL = 1'b1;
  localparam logic       SIDE_BUY   = 1'b0;
  localparam logic [2:0] OT_LIMIT   = 3'd0;
  localparam logic [2:0] OT_MARKET  = 3'd1;
  localparam logic [2:0] OT_IOC     = 3'd2;
  localparam logic [2:0] OT_POST    = 3'd3;
  localparam logic [2:0] OT_FOK     = 3'd4;

  // Report kinds
  localparam logic [1:0] RK_ACK    = 2'd0;
  localparam logic [1:0] RK_FILL   = 2'd1;
  localparam logic [1:0] RK_REJECT = 2'd2;
  localparam logic [1:0] RK_CANCEL = 2'd3;

  // Reject reasons
  localparam logic [2:0] RJ_NONE      = 3'd0;
  localparam logic [2:0] RJ_SYMBOL    = 3'd1;
  localparam logic [2:0] RJ_EMPTY     = 3'd2;
  localparam logic [2:0] RJ_CROSS     = 3'd3;
  localparam logic [2:0] RJ_LIQUIDITY = 3'd4;
  localparam logic [2:0] RJ_NOT_FOUND = 3'd5;
  localparam logic [2:0] RJ_FULL      = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  order_type;
    logic        side;
    logic [15:0] symbol;
    logic [31:0] order_ident;
    logic [15:0] lim_px;
    logic [31:0] quantity;
    logic [62:0] timestamp;
  } order_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [31:0] report_order;
    logic        report_side;
    logic [15:0] report_price;
    logic [31:0] report_qty;
    logic [62:0] report_time;
    logic [2:0]  reject_code;
    logic        last;
  } report_t;

  // Search request broadcast to every cell
  typedef struct packed {
    logic        is_cancel;
    logic        side;
    logic [31:0] ident;
    logic [15:0] price;
    logic [31:0] arrival;
  } query_t;

  // Running search result handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       order;
    logic              side;
    logic [15:0]       price;
    logic [31:0]       rem;
    logic [31:0]       age;
    logic [AVAIL_W-1:0] avail;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } carry_t;

  typedef enum logic [2:0] {
    WR_CLEAR = 3'b001,
    WR_REM   = 3'b010,
    WR_REST  = 3'b100
  } wr_op_t;

  typedef struct packed {
    logic              en;
    wr_op_t            op;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       order;
    logic              side;
    logic [15:0]       price;
    logic [31:0]       rem;
    logic [31:0]       arrival;
  } slot_wr_t;

  function automatic logic crosses(logic aside, logic [15:0] lim, logic [15:0] rp);
    return (aside == SIDE_BUY) ? (rp <= lim) : (rp >= lim);
  endfunction

  function automatic report_t mk_rep(logic [1:0] kind, logic [31:0] ord, logic side,
                                     logic [15:0] price, logic [31:0] qty,
                                     logic [62:0] ts, logic [2:0] code);
    report_t r;
    r.report_kind  = kind;
    r.report_order = ord;
    r.report_side  = side;
    r.report_price = price;
    r.report_qty   = qty;
    r.report_time  = ts;
    r.reject_code  = code;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// File: hw/rtl/loc_cell.sv
// One order slot: holds a resting order and folds it into the passing search carry.
module loc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [loc_pkg::SLOT_W-1:0] idx,
  input  loc_pkg::query_t           query,
  input  loc_pkg::slot_wr_t         wr,
  input  loc_pkg::carry_t           carry_in,
  output loc_pkg::carry_t           carry_out
);
  import loc_pkg::*;

  logic        valid;
  logic [31:0] order;
  logic        side;
  logic [15:0] price;
  logic [31:0] rem;
  logic [31:0] arrival;

  carry_t      carry_next;
  logic [31:0] age;
  logic        better;
  logic        take;

  // Slot storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.idx == idx) begin
      case (wr.op)
        WR_CLEAR: valid <= 1'b0;
        WR_REM:   rem <= wr.rem;
        WR_REST: begin
          valid   <= 1'b1;
          order   <= wr.order;
          side    <= wr.side;
          price   <= wr.price;
          rem     <= wr.rem;
          arrival <= wr.arrival;
        end
        default: valid <= valid;
      endcase
    end
  end

  // Fold this slot into the carry
  always_comb begin
    carry_next = carry_in;
    age        = query.arrival - arrival;
    if (query.side == SIDE_BUY) begin
      better = price < carry_in.price;
    end else begin
      better = price > carry_in.price;
    end
    if (!better && price == carry_in.price) begin
      better = age > carry_in.age;
    end
    if (query.is_cancel) begin
      take = valid && order == query.ident && !carry_in.found;
    end else begin
      take = valid && side != query.side && (!carry_in.found || better);
      if (valid && side != query.side && crosses(query.side, query.price, price)) begin
        carry_next.avail = carry_in.avail + AVAIL_W'(rem);
      end
    end
    if (take) begin
      carry_next.found = 1'b1;
      carry_next.idx   = idx;
      carry_next.order = order;
      carry_next.side  = side;
      carry_next.price = price;
      carry_next.rem   = rem;
      carry_next.age   = age;
    end
    if (!valid && !carry_in.free_found) begin
      carry_next.free_found = 1'b1;
      carry_next.free_idx   = idx;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

endmodule

// File: hw/rtl/loc_ctrl.sv
// Sequencer: runs slot searches, decides reports and updates the slots.
module loc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         book_symbol,
  input  logic                order_valid,
  output logic                order_ready,
  input  loc_pkg::order_t     order,
  output logic                report_valid,
  input  logic                report_ready,
  output loc_pkg::report_t    report,
  output loc_pkg::query_t     query,
  output loc_pkg::slot_wr_t   wr,
  input  loc_pkg::carry_t     tail
);
  import loc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_FILL_M = 6'b001000,
    S_FILL_T = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t      state;
  logic        sweeping;
  order_t      item;
  logic [31:0] rem;
  logic [31:0] fill;
  logic [31:0] arrival_count;
  logic [SCAN_W-1:0] scan_cnt;
  report_t     pend;
  logic        pend_valid;

  logic        out_free;
  logic        produce;
  report_t     prod_rep;
  report_t     last_rep;
  logic        limit_like;
  logic        can_fill;

  assign order_ready = (state == S_IDLE);
  assign out_free    = !report_valid || report_ready;
  assign limit_like  = !(item.order_type inside {OT_MARKET, OT_IOC, OT_POST, OT_FOK});
  assign can_fill    = rem != 32'd0 && tail.found && crosses(item.side, query.price, tail.price);

  // Which report a state hands over this cycle
  always_comb begin
    produce  = 1'b0;
    prod_rep = mk_rep(RK_ACK, item.order_ident, item.side, item.lim_px,
                      item.quantity, item.timestamp, RJ_NONE);
    if (out_free) begin
      case (state)
        S_DECIDE: begin
          if (!sweeping) begin
            produce = 1'b1;
            if (item.cmd == CMD_CANCEL) begin
              if (tail.found) begin
                prod_rep = mk_rep(RK_CANCEL, item.order_ident, tail.side, tail.price,
                                  tail.rem, item.timestamp, RJ_NONE);
              end else begin
                prod_rep = mk_rep(RK_REJECT, item.order_ident, 1'b0, 16'd0, 32'd0,
                                  item.timestamp, RJ_NOT_FOUND);
              end
            end else if (item.symbol != book_symbol) begin
              prod_rep.report_kind = RK_REJECT;
              prod_rep.reject_code = RJ_SYMBOL;
            end else if (item.order_type == OT_MARKET && !tail.found) begin
              prod_rep.report_kind = RK_REJECT;
              prod_rep.reject_code = RJ_EMPTY;
            end else if (item.order_type == OT_POST) begin
              if (tail.found && crosses(item.side, item.lim_px, tail.price)) begin
                prod_rep.report_kind = RK_REJECT;
                prod_rep.reject_code = RJ_CROSS;
              end else if (item.quantity != 32'd0 && !tail.free_found) begin
                prod_rep.report_kind = RK_REJECT;
                prod_rep.reject_code = RJ_FULL;
              end
            end else if (item.order_type == OT_FOK &&
                         tail.avail < AVAIL_W'(item.quantity)) begin
              prod_rep.report_kind = RK_REJECT;
              prod_rep.reject_code = RJ_LIQUIDITY;
            end
          end else if (!can_fill && limit_like && rem != 32'd0 && !tail.free_found) begin
            produce  = 1'b1;
            prod_rep = mk_rep(RK_REJECT, item.order_ident, item.side, item.lim_px,
                              rem, item.timestamp, RJ_FULL);
          end
        end
        S_FILL_M: begin
          produce  = 1'b1;
          prod_rep = mk_rep(RK_FILL, tail.order, tail.side, tail.price, fill,
                            item.timestamp, RJ_NONE);
        end
        S_FILL_T: begin
          produce  = 1'b1;
          prod_rep = mk_rep(RK_FILL, item.order_ident, item.side, tail.price, fill,
                            item.timestamp, RJ_NONE);
        end
        default: produce = 1'b0;
      endcase
    end
  end

  // Final beat of an item carries last
  always_comb begin
    last_rep      = pend;
    last_rep.last = 1'b1;
  end

  // Output register: a report leaves one step behind so its last flag is known
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      if (report_valid && report_ready) begin
        report_valid <= 1'b0;
      end
      if (produce) begin
        pend       <= prod_rep;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          report       <= pend;
          report_valid <= 1'b1;
        end
      end else if (state == S_FINISH && out_free) begin
        report       <= last_rep;
        report_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      arrival_count <= 32'd0;
      wr.en         <= 1'b0;
      sweeping      <= 1'b0;
    end else begin
      wr.en <= 1'b0;
      case (state)
        S_IDLE: begin
          if (order_valid) begin
            item            <= order;
            rem             <= order.quantity;
            sweeping        <= 1'b0;
            query.is_cancel <= order.cmd;
            query.side      <= order.side;
            query.ident     <= order.order_ident;
            query.arrival   <= arrival_count;
            if (order.order_type == OT_MARKET) begin
              query.price <= (order.side == SIDE_BUY) ? PRICE_MAX : PRICE_MIN;
            end else begin
              query.price <= order.lim_px;
            end
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt == SCAN_W'(ORDER_SLOTS + 1)) begin
            state <= S_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            scan_cnt <= '0;
            if (!sweeping) begin
              if (item.cmd == CMD_CANCEL) begin
                state <= S_FINISH;
                if (tail.found) begin
                  wr.en  <= 1'b1;
                  wr.op  <= WR_CLEAR;
                  wr.idx <= tail.idx;
                end
              end else if (item.symbol != book_symbol) begin
                state <= S_FINISH;
              end else if (item.order_type == OT_POST) begin
                state <= S_FINISH;
                if (!(tail.found && crosses(item.side, item.lim_px, tail.price)) &&
                    item.quantity != 32'd0 && tail.free_found) begin
                  wr.en      <= 1'b1;
                  wr.op      <= WR_REST;
                  wr.idx     <= tail.free_idx;
                  wr.order   <= item.order_ident;
                  wr.side    <= item.side;
                  wr.price   <= item.lim_px;
                  wr.rem     <= item.quantity;
                  wr.arrival <= arrival_count;
                  arrival_count <= arrival_count + 32'd1;
                end
              end else if (!(item.order_type == OT_MARKET && !tail.found) &&
                           !(item.order_type == OT_FOK &&
                             tail.avail < AVAIL_W'(item.quantity))) begin
                sweeping <= 1'b1;
                state    <= S_SCAN;
              end else begin
                state <= S_FINISH;
              end
            end else if (can_fill) begin
              fill  <= (rem < tail.rem) ? rem : tail.rem;
              state <= S_FILL_M;
            end else begin
              state <= S_FINISH;
              if (limit_like && rem != 32'd0 && tail.free_found) begin
                wr.en      <= 1'b1;
                wr.op      <= WR_REST;
                wr.idx     <= tail.free_idx;
                wr.order   <= item.order_ident;
                wr.side    <= item.side;
                wr.price   <= item.lim_px;
                wr.rem     <= rem;
                wr.arrival <= arrival_count;
                arrival_count <= arrival_count + 32'd1;
              end
            end
          end
        end
        S_FILL_M: begin
          if (out_free) begin
            state <= S_FILL_T;
          end
        end
        S_FILL_T: begin
          if (out_free) begin
            wr.en  <= 1'b1;
            wr.idx <= tail.idx;
            wr.rem <= tail.rem - fill;
            wr.op  <= (fill == tail.rem) ? WR_CLEAR : WR_REM;
            rem    <= rem - fill;
            scan_cnt <= '0;
            state  <= S_SCAN;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/limit_order_book_matcher_unit.sv
// Top level: configuration register, row of slot cells and the sequencer.
//
//   channel  direction  payload          handshake
//   order    in         loc_pkg::order_t order_valid / order_ready
//   report   out        loc_pkg::report_t report_valid / report_ready
//   cfg      in         book symbol (16) cfg_valid / cfg_ready
//
// A slot search scans until the carry has crossed every cell after the last slot write,
// then decides. A reject, cancel or post-only order takes one search from accept to accept;
// a sweeping order adds a second search, and a further search after each fill pair.
// One item at a time. Reset empties every slot at once. A stalled report output
// holds the sequencer in place; the final report of an item carries last.
module limit_order_book_matcher_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              order_valid,
  output logic              order_ready,
  input  loc_pkg::order_t   order,
  output logic              report_valid,
  input  logic              report_ready,
  output loc_pkg::report_t  report,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import loc_pkg::*;

  logic [15:0] book_symbol;
  query_t      query;
  slot_wr_t    wr;
  carry_t      chain [ORDER_SLOTS+1];

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      book_symbol <= 16'd0;
    end else if (cfg_valid) begin
      book_symbol <= cfg_data;
    end
  end

  // Empty carry enters the first cell
  assign chain[0] = '0;

  for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
    loc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (SLOT_W'(i)),
      .query     (query),
      .wr        (wr),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1])
    );
  end

  loc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .book_symbol  (book_symbol),
    .order_valid  (order_valid),
    .order_ready  (order_ready),
    .order        (order),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .query        (query),
    .wr           (wr),
    .tail         (chain[ORDER_SLOTS])
  );

endmodule
